FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/idq_pkg.sv
// types and constants of the indexed double-ended queue
package idq_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int POS_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_INSERT     = 3'd4,
      FN_DELETE     = 3'd5,
      FN_SWAP       = 3'd6,
      FN_READ       = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SWAP
   } state_type;

   typedef struct packed {
      func_type         func;
      logic [31:0]      data_in;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] second_position;
   } req_type;

   typedef struct packed {
      logic [31:0]      data_out;
      logic [CNT_W-1:0] count_now;
      status_type       status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic swap_second;
      logic respond;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic swap_go;
   } dp_stat_type;

endpackage

FILE: hw/rtl/indexed_double_ended_queue_top.sv
// indexed double-ended queue: command sequencer plus entry-cell datapath
// the accepting edge latches the command, S_EXEC runs it (swap: then S_SWAP), and
// the result register raises the strobe; no new command is taken while busy; cells
//   shift in one update; swap takes a second pass through the single read port
// the result register drives rsp_strobe for one cycle; the receiver cannot stall
// reset clears the count, the sequencer and the strobe; entry cells are not cleared
module indexed_double_ended_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  idq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output idq_pkg::rsp_type rsp_data
);
   import idq_pkg::*;

   ctl_type     ctl;
   dp_stat_type stat;

   idq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   idq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .ctl        (ctl),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hw/rtl/idq_ctrl.sv
// command sequencer of the queue
module idq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  idq_pkg::dp_stat_type stat,
   output idq_pkg::ctl_type    ctl
);
   import idq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            ctl.load = start;
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            if (stat.swap_go) begin
               state_in = S_SWAP;
            end else begin
               ctl.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SWAP: begin
            ctl.swap_second = 1'b1;
            ctl.respond     = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/idq_datapath.sv
// entry cells, count, operand latch and result register of the queue
module idq_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  idq_pkg::req_type     req_data,
   input  idq_pkg::ctl_type     ctl,
   output idq_pkg::dp_stat_type stat,
   output logic                 rsp_strobe,
   output idq_pkg::rsp_type     rsp_data
);
   import idq_pkg::*;

   req_type              cmd_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DATA_W-1:0]    ent_ff [DEPTH];
   logic [DATA_W-1:0]    ent_in [DEPTH];
   logic [DATA_W-1:0]    temp_ff, temp_in;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_ff;

   logic [CNT_W-1:0]     cnt_m1;
   logic [POS_W-1:0]     rd_addr;
   logic [DATA_W-1:0]    rd_data;
   logic                 full, empty, pos_ok, pos2_ok, ins_ok;
   status_type           st;
   logic [31:0]          dout;
   logic                 open_en, close_en;
   logic [POS_W-1:0]     shift_at;
   logic                 wa_en, wb_en;
   logic [POS_W-1:0]     wa_addr, wb_addr;
   logic [DATA_W-1:0]    wa_data, wb_data;

   assign cnt_m1  = count_ff - CNT_W'(1);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pos_ok  = (CNT_W'(cmd_ff.position) < count_ff);
   assign pos2_ok = (CNT_W'(cmd_ff.second_position) < count_ff);
   assign ins_ok  = (CNT_W'(cmd_ff.position) <= count_ff);

   // single read port
   always_comb begin
      if (ctl.swap_second) begin
         rd_addr = cmd_ff.second_position;
      end else begin
         case (cmd_ff.func)
            FN_POP_FRONT: rd_addr = '0;
            FN_POP_BACK:  rd_addr = cnt_m1[POS_W-1:0];
            default:      rd_addr = cmd_ff.position;
         endcase
      end
   end
   assign rd_data = ent_ff[rd_addr];

   always_comb begin
      st           = ST_OK;
      dout         = '0;
      count_in     = count_ff;
      open_en      = 1'b0;
      close_en     = 1'b0;
      shift_at     = cmd_ff.position;
      wa_en        = 1'b0;
      wa_addr      = cmd_ff.position;
      wa_data      = cmd_ff.data_in;
      wb_en        = 1'b0;
      wb_addr      = cmd_ff.second_position;
      wb_data      = temp_ff;
      temp_in      = temp_ff;
      stat.swap_go = 1'b0;
      if (ctl.exec) begin
         case (cmd_ff.func)
            FN_PUSH_FRONT: begin
               if (full) begin
                  st = ST_FULL;
               end else begin
                  open_en  = 1'b1;
                  shift_at = '0;
                  wa_en    = 1'b1;
                  wa_addr  = '0;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FN_PUSH_BACK: begin
               if (full) begin
                  st = ST_FULL;
               end else begin
                  wa_en    = 1'b1;
                  wa_addr  = count_ff[POS_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FN_POP_FRONT: begin
               if (empty) begin
                  st = ST_IGNORED;
               end else begin
                  dout     = rd_data;
                  close_en = 1'b1;
                  shift_at = '0;
                  count_in = cnt_m1;
               end
            end
            FN_POP_BACK: begin
               if (empty) begin
                  st = ST_IGNORED;
               end else begin
                  dout     = rd_data;
                  count_in = cnt_m1;
               end
            end
            FN_INSERT: begin
               if (!ins_ok) begin
                  st = ST_IGNORED;
               end else if (full) begin
                  st = ST_FULL;
               end else begin
                  open_en  = 1'b1;
                  wa_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FN_DELETE: begin
               if (!pos_ok) begin
                  st = ST_IGNORED;
               end else begin
                  dout     = rd_data;
                  close_en = 1'b1;
                  count_in = cnt_m1;
               end
            end
            FN_SWAP: begin
               if (!(pos_ok && pos2_ok)) begin
                  st = ST_IGNORED;
               end else begin
                  // first half: keep the word at position
                  temp_in      = rd_data;
                  stat.swap_go = 1'b1;
               end
            end
            FN_READ: begin
               if (!pos_ok) begin
                  st = ST_IGNORED;
               end else begin
                  dout = rd_data;
               end
            end
            default: begin
               st = ST_IGNORED;
            end
         endcase
      end else if (ctl.swap_second) begin
         wa_en   = 1'b1;
         wa_data = rd_data;
         wb_en   = 1'b1;
      end
   end

   // each cell sees only its neighbors and the two write ports
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] prev_word, next_word;
      if (i == 0) begin : g_first
         assign prev_word = ent_ff[0];
      end else begin : g_prev
         assign prev_word = ent_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_word = ent_ff[i];
      end else begin : g_next
         assign next_word = ent_ff[i+1];
      end
      always_comb begin
         ent_in[i] = ent_ff[i];
         if (open_en && (POS_W'(i) > shift_at)) begin
            ent_in[i] = prev_word;
         end
         if (close_en && (POS_W'(i) >= shift_at)) begin
            ent_in[i] = next_word;
         end
         if (wa_en && (wa_addr == POS_W'(i))) begin
            ent_in[i] = wa_data;
         end
         if (wb_en && (wb_addr == POS_W'(i))) begin
            ent_in[i] = wb_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_ff[i] <= ent_in[i];
      end
      temp_ff <= temp_in;
      if (ctl.load) begin
         cmd_ff <= req_data;
      end
      if (ctl.respond) begin
         rsp_ff.data_out  <= dout;
         rsp_ff.count_now <= count_in;
         rsp_ff.status    <= st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= ctl.respond;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: hw/rtl/idq_checker.sv
// port-level checks of the queue and their binding to the top level
`include "assert_macros.svh"

module idq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input idq_pkg::rsp_type rsp_data
);
   import idq_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // a taken command keeps the block busy until its word is out
   `ASSERT_NEXT(a_busy_after_accept, accept, busy)
   // no stale word in the cycle after a command is taken
   `ASSERT_NEXT(a_quiet_after_accept, accept, !rsp_strobe)
   // one word per command, never two in a row
   `ASSERT_NEXT(a_single_word, rsp_strobe, !rsp_strobe)
   // failed commands return zero and a count within bounds
   `ASSERT_SAME(a_fail_zero, rsp_strobe && (rsp_data.status != ST_OK),
                (rsp_data.data_out == '0) && (rsp_data.count_now <= CNT_W'(DEPTH)))

endmodule

bind indexed_double_ended_queue_top idq_checker u_idq_checker (.*);
